/* rtl/core/opl_pkg.sv */
// ----------------------------------------------------------------------------
// opl_pkg
// Shared types, sizes and codes for the ordered point list and its cells.
// ----------------------------------------------------------------------------
package opl_pkg;

   // list geometry
   localparam int CAPACITY   = 64;
   localparam int COORD_BITS = 16;
   localparam int POS_W      = $clog2(CAPACITY);
   localparam int LEN_W      = $clog2(CAPACITY + 1);

   // fixed field widths of the request and response items
   localparam int OPCODE_W   = 3;
   localparam int INDEX_W    = 6;
   localparam int STATUS_W   = 2;
   localparam int LIST_LEN_W = 7;

   // width wide enough to compare an index against the length
   localparam int CMP_W = (LEN_W > INDEX_W) ? LEN_W : INDEX_W;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_APPEND       = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_INSERT       = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_READ         = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_REMOVE_INDEX = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_REMOVE_MATCH = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
   } point_type;

   // broadcast control from the top level to every cell
   typedef struct packed {
      logic             ins_en;        // write pt at pos, shift tail right
      logic             rem_idx_en;    // drop entry at pos, shift tail left
      logic             rem_match_en;  // drop first entry equal to pt
      logic [POS_W-1:0] pos;
      logic [LEN_W-1:0] length;
      point_type        pt;
   } cell_ctrl_type;

endpackage

/* rtl/core/opl_cell.sv */
// ----------------------------------------------------------------------------
// opl_cell
// One list slot: holds a point, shifts with its neighbors on insert and
// remove, compares against the search point and drives the read bus.
// ----------------------------------------------------------------------------
module opl_cell
   import opl_pkg::*;
(
   input  logic          clock,
   input  logic [POS_W-1:0] my_pos,
   input  cell_ctrl_type ctrl,
   input  point_type     left_data,
   input  point_type     right_data,
   input  logic          found_in,
   output logic          found_out,
   output point_type     data_out,
   output point_type     rd_out
);

   point_type data_ff;
   point_type data_in;
   logic      valid;
   logic      hit;
   logic      shift_left;

   // match only against occupied slots
   assign valid     = LEN_W'(my_pos) < ctrl.length;
   assign hit       = valid && (data_ff == ctrl.pt);
   assign found_out = found_in | hit;

   assign shift_left = (ctrl.rem_idx_en && (my_pos >= ctrl.pos))
                     || (ctrl.rem_match_en && found_out);

   // select the next content of this slot
   always_comb begin
      data_in = data_ff;
      if (ctrl.ins_en) begin
         if (my_pos == ctrl.pos) begin
            data_in = ctrl.pt;
         end else if (my_pos > ctrl.pos) begin
            data_in = left_data;
         end
      end else if (shift_left) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   assign rd_out   = (my_pos == ctrl.pos) ? data_ff : '0;

endmodule

/* rtl/core/ordered_point_list.sv */
// ----------------------------------------------------------------------------
// ordered_point_list
// Bounded ordered list of 2-D points kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one operation per item: append, insert before
//   an index, read an index, remove an index, or remove the first entry
//   equal to the given point. Every request item yields exactly one rsp_
//   item with a point, a status and the list length after the operation.
//   Every cell updates in the same cycle (neighbor shift on insert and
//   remove, compare in each cell for the match search); the response is
//   registered and shows up the cycle after acceptance, and a new request is
//   taken every cycle while the response register is free or being taken.
//   The output register frees as its item is taken, so req_ready stays high
//   while rsp_ready is high; when the receiver stalls with a response
//   waiting, req_ready drops and the list holds.
//   Reset empties the list (length zero) and clears the response valid;
//   cell contents are not cleared, since slots at or beyond the length are
//   never read.
// ----------------------------------------------------------------------------
module ordered_point_list
   import opl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OPCODE_W-1:0]   req_opcode,
   input  logic [INDEX_W-1:0]    req_index,
   input  logic [COORD_BITS-1:0] req_point_x,
   input  logic [COORD_BITS-1:0] req_point_y,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COORD_BITS-1:0] rsp_out_x,
   output logic [COORD_BITS-1:0] rsp_out_y,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [LIST_LEN_W-1:0] rsp_list_length
);

   logic [LEN_W-1:0]      length_ff;
   logic [LEN_W-1:0]      length_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   point_type             rsp_point_ff;
   point_type             rsp_point_in;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [STATUS_W-1:0]   rsp_status_in;

   logic                  req_fire;
   logic [CMP_W-1:0]      idx_cmp;
   logic [CMP_W-1:0]      len_cmp;
   logic                  idx_ok;
   logic                  not_full;
   logic                  any_found;
   logic                  do_ins;
   logic                  do_rem;
   point_type             req_point;
   point_type             rd_point;
   point_type             all_ones;
   cell_ctrl_type         ctrl;

   point_type             cell_data [CAPACITY];
   point_type             cell_rd   [CAPACITY];
   logic [CAPACITY:0]     found;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;

   assign req_point.x = req_point_x;
   assign req_point.y = req_point_y;
   assign all_ones    = '1;

   assign idx_cmp  = CMP_W'(req_index);
   assign len_cmp  = CMP_W'(length_ff);
   assign idx_ok   = idx_cmp < len_cmp;
   assign not_full = length_ff < LEN_W'(CAPACITY);

   assign any_found = found[CAPACITY];

   // decode the operation and form the response
   always_comb begin
      do_ins        = 1'b0;
      do_rem        = 1'b0;
      rsp_point_in  = '0;
      rsp_status_in = ST_OK;
      ctrl          = '0;
      ctrl.length   = length_ff;
      ctrl.pt       = req_point;
      ctrl.pos      = POS_W'(idx_cmp);
      unique case (req_opcode)
         OP_APPEND: begin
            ctrl.pos = length_ff[POS_W-1:0];
            if (not_full) begin
               do_ins = 1'b1;
            end else begin
               rsp_status_in = ST_FULL;
            end
         end
         OP_INSERT: begin
            if (!idx_ok) begin
               rsp_status_in = ST_RANGE;
            end else if (!not_full) begin
               rsp_status_in = ST_FULL;
            end else begin
               do_ins = 1'b1;
            end
         end
         OP_READ, OP_REMOVE_INDEX: begin
            if (idx_ok) begin
               rsp_point_in = rd_point;
               do_rem       = (req_opcode == OP_REMOVE_INDEX);
            end else begin
               rsp_point_in  = all_ones;
               rsp_status_in = ST_RANGE;
            end
         end
         OP_REMOVE_MATCH: begin
            if (any_found) begin
               rsp_point_in = req_point;
               do_rem       = 1'b1;
            end else begin
               rsp_status_in = ST_MISSING;
            end
         end
         default: begin
         end
      endcase
      ctrl.ins_en       = req_fire && do_ins;
      ctrl.rem_idx_en   = req_fire && do_rem && (req_opcode == OP_REMOVE_INDEX);
      ctrl.rem_match_en = req_fire && (req_opcode == OP_REMOVE_MATCH);
   end

   // advance the length
   always_comb begin
      length_in = length_ff;
      if (req_fire && do_ins) begin
         length_in = length_ff + LEN_W'(1);
      end else if (req_fire && do_rem) begin
         length_in = length_ff - LEN_W'(1);
      end
   end

   // row of cells
   assign found[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      point_type left_data;
      point_type right_data;

      if (i == 0) begin : g_first
         assign left_data = req_point;
      end else begin : g_inner_l
         assign left_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_inner_r
         assign right_data = cell_data[i+1];
      end

      opl_cell u_cell (
         .clock      (clock),
         .my_pos     (POS_W'(i)),
         .ctrl       (ctrl),
         .left_data  (left_data),
         .right_data (right_data),
         .found_in   (found[i]),
         .found_out  (found[i+1]),
         .data_out   (cell_data[i]),
         .rd_out     (cell_rd[i])
      );
   end

   // collect the read bus; at most one cell drives it
   always_comb begin
      rd_point = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_point = rd_point | cell_rd[i];
      end
   end

   // hold the response until taken
   assign rsp_valid_in = req_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         length_ff    <= length_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_point_ff  <= rsp_point_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   logic [LEN_W-1:0] rsp_length_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_length_ff <= length_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_x       = rsp_point_ff.x;
   assign rsp_out_y       = rsp_point_ff.y;
   assign rsp_status      = rsp_status_ff;
   assign rsp_list_length = LIST_LEN_W'(rsp_length_ff);

   // checks
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      length_ff <= LEN_W'(CAPACITY))
      else $error("list length beyond capacity");

   a_len_hold: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(length_ff))
      else $error("length changed without an accepted item");

   a_ins_grow: assert property (@(posedge clock) disable iff (reset)
      (req_fire && do_ins) |=> (length_ff == $past(length_ff) + LEN_W'(1)))
      else $error("insert did not grow the list by one");

   a_full_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_FULL)) |-> (rsp_length_ff == LEN_W'(CAPACITY)))
      else $error("full status with a list that is not full");

   a_one_op: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl.ins_en, ctrl.rem_idx_en, ctrl.rem_match_en}))
      else $error("more than one cell operation at once");

endmodule

/* bench/ordered_point_list_tb.sv */
// ----------------------------------------------------------------------------
// ordered_point_list_tb
// Self-checking bench for the ordered point list. A scoreboard keeps its own
// copy of the list, predicts the response of every accepted request and
// compares the responses in order. A short directed run covers empty, edge
// and unused-opcode cases. Random phases then grow the list toward full, hold it
// there and shrink it toward empty. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module ordered_point_list_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import opl_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 80;
   localparam int PHASES         = 14;
   localparam int PHASE_ITEMS    = 100;
   localparam int DRAIN_CYCLES   = 4;
   localparam int PRINT_CAP      = 40;

   // opcodes the block ignores
   localparam logic [OPCODE_W-1:0] OP_SPARE_A = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_SPARE_B = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_SPARE_C = 3'd7;

   typedef enum {MIX_GROW, MIX_BALANCED, MIX_SHRINK} op_mix_type;

   typedef struct {
      point_type             pt;
      logic [STATUS_W-1:0]   status;
      logic [LIST_LEN_W-1:0] length;
   } rsp_expect_type;

   // Track list contents and the responses still owed by the block.
   class point_list_tracker_type;
      point_type      pts [CAPACITY];
      int             list_len;
      rsp_expect_type expected_rsp [$];
      int             mismatches;
      int             rsp_count;
      int             op_count [8];
      int             status_count [4];
      int             peak_len;

      function new();
         list_len   = 0;
         mismatches = 0;
         rsp_count  = 0;
         peak_len   = 0;
         foreach (op_count[i]) op_count[i] = 0;
         foreach (status_count[i]) status_count[i] = 0;
      endfunction

      task report(string msg);
         if (mismatches < PRINT_CAP) $display("MISMATCH: %s", msg);
         mismatches++;
      endtask

      // close the gap left by the entry at pos
      function void drop_entry(int pos);
         int k;
         for (k = pos; k + 1 < list_len; k++) pts[k] = pts[k + 1];
         list_len--;
      endfunction

      // Apply one accepted request to the list and queue its response.
      function void note_request(logic [OPCODE_W-1:0] op, logic [INDEX_W-1:0] idx,
                                 logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
         rsp_expect_type rsp;
         int             k;
         rsp.pt     = '0;
         rsp.status = ST_OK;
         op_count[op]++;
         case (op)
            OP_APPEND: begin
               if (list_len >= CAPACITY) begin
                  rsp.status = ST_FULL;
               end else begin
                  pts[list_len] = {px, py};
                  list_len++;
               end
            end
            OP_INSERT: begin
               if (idx >= list_len) begin
                  rsp.status = ST_RANGE;
               end else if (list_len >= CAPACITY) begin
                  rsp.status = ST_FULL;
               end else begin
                  for (k = list_len; k > idx; k--) pts[k] = pts[k - 1];
                  pts[idx] = {px, py};
                  list_len++;
               end
            end
            OP_READ, OP_REMOVE_INDEX: begin
               if (idx >= list_len) begin
                  rsp.status = ST_RANGE;
                  rsp.pt     = '1;
               end else begin
                  rsp.pt = pts[idx];
                  if (op == OP_REMOVE_INDEX) drop_entry(idx);
               end
            end
            OP_REMOVE_MATCH: begin
               rsp.status = ST_MISSING;
               for (k = 0; k < list_len; k++) begin
                  if (pts[k] == {px, py}) begin
                     rsp.pt     = pts[k];
                     rsp.status = ST_OK;
                     drop_entry(k);
                     break;
                  end
               end
            end
            default: ;
         endcase
         rsp.length = LIST_LEN_W'(list_len);
         status_count[rsp.status]++;
         if (list_len > peak_len) peak_len = list_len;
         expected_rsp.push_back(rsp);
      endfunction

      // Compare one response with the oldest prediction.
      task check_response(input logic [COORD_BITS-1:0] got_x,
                          input logic [COORD_BITS-1:0] got_y,
                          input logic [STATUS_W-1:0]   got_st,
                          input logic [LIST_LEN_W-1:0] got_len);
         rsp_expect_type want;
         rsp_count++;
         if (expected_rsp.size() == 0) begin
            report($sformatf("response %0d arrived with no request pending", rsp_count));
            return;
         end
         want = expected_rsp.pop_front();
         if (got_x !== want.pt.x)
            report($sformatf("response %0d out_x %h, want %h", rsp_count, got_x, want.pt.x));
         if (got_y !== want.pt.y)
            report($sformatf("response %0d out_y %h, want %h", rsp_count, got_y, want.pt.y));
         if (got_st !== want.status)
            report($sformatf("response %0d status %0d, want %0d",
                             rsp_count, got_st, want.status));
         if (got_len !== want.length)
            report($sformatf("response %0d list_length %0d, want %0d",
                             rsp_count, got_len, want.length));
      endtask
   endclass

   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_ready;
   logic [OPCODE_W-1:0]   req_opcode      = OP_APPEND;
   logic [INDEX_W-1:0]    req_index       = '0;
   logic [COORD_BITS-1:0] req_point_x     = '0;
   logic [COORD_BITS-1:0] req_point_y     = '0;
   logic                  rsp_valid;
   logic                  rsp_ready       = 1'b0;
   logic [COORD_BITS-1:0] rsp_out_x;
   logic [COORD_BITS-1:0] rsp_out_y;
   logic [STATUS_W-1:0]   rsp_status;
   logic [LIST_LEN_W-1:0] rsp_list_length;

   point_list_tracker_type tracker;
   bit                sender_idle   = 1'b1;
   bit                receiver_idle = 1'b1;
   bit                hold_rsp_req  = 1'b0;
   int                holds_done    = 0;

   ordered_point_list i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_index       (req_index),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_status      (rsp_status),
      .rsp_list_length (rsp_list_length)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // full-range values, tiny values that collide, and the corners
   function automatic logic [COORD_BITS-1:0] rand_coord();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return COORD_BITS'($urandom);
      if (r < 85) return COORD_BITS'($urandom_range(0, 3));
      return ($urandom_range(0, 1) != 0) ? {COORD_BITS{1'b1}} : {COORD_BITS{1'b0}};
   endfunction

   function automatic logic [OPCODE_W-1:0] pick_opcode(op_mix_type mix);
      int r;
      int w_app, w_ins, w_rd, w_rmi, w_rmm;
      case (mix)
         MIX_GROW: begin
            w_app = 40; w_ins = 30; w_rd = 12; w_rmi = 8; w_rmm = 7;
         end
         MIX_BALANCED: begin
            w_app = 22; w_ins = 22; w_rd = 20; w_rmi = 16; w_rmm = 16;
         end
         default: begin
            w_app = 10; w_ins = 8; w_rd = 15; w_rmi = 35; w_rmm = 28;
         end
      endcase
      r = $urandom_range(0, 99);
      if (r < w_app) return OP_APPEND;
      r -= w_app;
      if (r < w_ins) return OP_INSERT;
      r -= w_ins;
      if (r < w_rd) return OP_READ;
      r -= w_rd;
      if (r < w_rmi) return OP_REMOVE_INDEX;
      r -= w_rmi;
      if (r < w_rmm) return OP_REMOVE_MATCH;
      return OPCODE_W'($urandom_range(OP_SPARE_A, OP_SPARE_C));
   endfunction

   // Offer one item, hold it until taken, then maybe idle.
   task automatic send_item(input logic [OPCODE_W-1:0]   op,
                            input logic [INDEX_W-1:0]    idx,
                            input logic [COORD_BITS-1:0] px,
                            input logic [COORD_BITS-1:0] py);
      int gap;
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_index   <= idx;
      req_point_x <= px;
      req_point_y <= py;
      do @(posedge clock); while (!req_ready);
      gap = sender_idle ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Build a random item around the current list contents.
   task automatic send_random(input logic [OPCODE_W-1:0] op);
      int                    len, r, k;
      logic [INDEX_W-1:0]    idx;
      logic [COORD_BITS-1:0] px, py;
      len = tracker.list_len;
      r   = $urandom_range(0, 9);
      if (r < 8 && len > 0) idx = INDEX_W'($urandom_range(0, len - 1));
      else if (r == 8)      idx = INDEX_W'(len);
      else                  idx = INDEX_W'($urandom);
      px = rand_coord();
      py = rand_coord();
      // aim most match removals at a stored point
      if (op == OP_REMOVE_MATCH && len > 0 && $urandom_range(0, 3) != 0) begin
         k  = $urandom_range(0, len - 1);
         px = tracker.pts[k].x;
         py = tracker.pts[k].y;
      end
      send_item(op, idx, px, py);
   endtask

   // Stop offering and hold until every response is back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_rsp.size() != 0) @(posedge clock);
   endtask

   // Observe both handshakes.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            tracker.note_request(req_opcode, req_index, req_point_x, req_point_y);
         if (rsp_valid && rsp_ready)
            tracker.check_response(rsp_out_x, rsp_out_y, rsp_status, rsp_list_length);
      end
   end

   // Drive rsp_ready: random runs and gaps, or a long hold on request.
   initial begin : rsp_side
      int run, gap;
      @(posedge clock);
      forever begin
         if (hold_rsp_req) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_rsp_req = 1'b0;
            holds_done++;
         end else begin
            run = receiver_idle ? $urandom_range(1, 6) : $urandom_range(20, 60);
            rsp_ready <= 1'b1;
            repeat (run) @(posedge clock);
            gap = receiver_idle ? pick_gap() : 0;
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   // End the run when no item moves for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      int                    phase, useful;
      op_mix_type            mix;
      logic [OPCODE_W-1:0]   op;
      tracker = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list: every access is out of range or not found
      send_item(OP_READ,         6'd0,  16'h0000, 16'h0000);
      send_item(OP_REMOVE_INDEX, 6'd63, 16'h0000, 16'h0000);
      send_item(OP_INSERT,       6'd0,  16'h1111, 16'h2222);
      send_item(OP_REMOVE_MATCH, 6'd0,  16'h0000, 16'h0000);
      // build a few entries, corners included
      send_item(OP_APPEND,       6'd0,  16'h0000, 16'h0000);
      send_item(OP_APPEND,       6'd63, 16'hFFFF, 16'hFFFF);
      send_item(OP_APPEND,       6'd0,  16'h1234, 16'hABCD);
      send_item(OP_INSERT,       6'd0,  16'h5555, 16'hAAAA);
      send_item(OP_INSERT,       6'd3,  16'h0001, 16'h8000);
      send_item(OP_INSERT,       6'd5,  16'h7777, 16'h7777);
      send_item(OP_INSERT,       6'd63, 16'h7777, 16'h7777);
      // reads at both ends and just past them
      send_item(OP_READ,         6'd0,  16'h0000, 16'h0000);
      send_item(OP_READ,         6'd4,  16'h0000, 16'h0000);
      send_item(OP_READ,         6'd5,  16'h0000, 16'h0000);
      send_item(OP_READ,         6'd63, 16'hFFFF, 16'hFFFF);
      // duplicate point: the first copy goes
      send_item(OP_APPEND,       6'd0,  16'h1234, 16'hABCD);
      send_item(OP_REMOVE_MATCH, 6'd0,  16'h1234, 16'hABCD);
      send_item(OP_REMOVE_MATCH, 6'd0,  16'h1234, 16'hABCE);
      send_item(OP_REMOVE_MATCH, 6'd9,  16'hFFFF, 16'hFFFF);
      send_item(OP_REMOVE_INDEX, 6'd0,  16'h0000, 16'h0000);
      send_item(OP_REMOVE_INDEX, 6'd2,  16'h0000, 16'h0000);
      send_item(OP_REMOVE_INDEX, 6'd63, 16'h0000, 16'h0000);
      // unused opcodes change nothing
      send_item(OP_SPARE_A,      6'd0,  16'hFFFF, 16'hFFFF);
      send_item(OP_SPARE_B,      6'd1,  16'h0000, 16'h0000);
      send_item(OP_SPARE_C,      6'd63, 16'hFFFF, 16'h0000);
      wait_drained();

      // fill toward full, hold there, shrink toward empty, twice over
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase % 7)
            0, 1:    mix = MIX_GROW;
            4, 5:    mix = MIX_SHRINK;
            default: mix = MIX_BALANCED;
         endcase
         sender_idle   = (phase % 3) != 1;
         receiver_idle = (phase % 4) != 2;
         // back-pressure: receiver stalls long while requests keep coming
         if (phase == 2 || phase == 9) begin
            hold_rsp_req = 1'b1;
            sender_idle  = 1'b0;
         end
         useful = 0;
         while (useful < PHASE_ITEMS) begin
            op = pick_opcode(mix);
            send_random(op);
            if (op <= OP_REMOVE_MATCH) useful++;
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d responses: append %0d, insert %0d, read %0d, remove at index %0d,",
               tracker.rsp_count, tracker.op_count[OP_APPEND], tracker.op_count[OP_INSERT],
               tracker.op_count[OP_READ], tracker.op_count[OP_REMOVE_INDEX]);
      $display({"  remove match %0d; ok %0d, range %0d, full %0d, not found %0d;",
                " peak %0d, stalls %0d"},
               tracker.op_count[OP_REMOVE_MATCH], tracker.status_count[ST_OK],
               tracker.status_count[ST_RANGE], tracker.status_count[ST_FULL],
               tracker.status_count[ST_MISSING], tracker.peak_len, holds_done);
      if (tracker.mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", tracker.mismatches);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
